// ===== rtl/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  // default geometry of the page bitmap
  localparam int unsigned MAX_PAGE_COUNT_DEF   = 4096;
  localparam int unsigned BITMAP_WORD_BITS_DEF = 32;

  // field widths
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ADDR_IN_W   = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ADDR_OUT_W  = 24;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned MEM_KB_W    = 23;
  localparam int unsigned RESERVED_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = MEM_KB_W;

  // 4 KB pages
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned PAGE_NUM_W  = ADDR_IN_W - PAGE_SHIFT;

  // reset value of the reserved page count, first 4 MB
  localparam logic [RESERVED_W-1:0] RESERVED_RST = RESERVED_W'(1024);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_KB      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 2'd1;

  // sequencer states
  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ASCAN = 6'b000100,
    S_FSEEK = 6'b001000,
    S_FREAD = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/bpa_if.sv =====
`default_nettype none

// request channel: one operation per beat
interface bpa_req_if import bpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ADDR_IN_W-1:0] free_address;

  modport source (output valid, output operation, output free_address, input ready);
  modport sink   (input valid, input operation, input free_address, output ready);
endinterface

// response channel: one result per beat
interface bpa_rsp_if import bpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ADDR_OUT_W-1:0] page_address;
  logic [COUNT_W-1:0]    free_count;

  modport source (output valid, output status, output page_address, output free_count,
                  input ready);
  modport sink   (input valid, input status, input page_address, input free_count,
                  output ready);
endinterface

// configuration write channel
interface bpa_cfg_if import bpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bitmap_page_allocator.sv =====
`default_nettype none

// First-fit physical page allocator over a bitmap of 4 KB pages (1 = used).
// req_i carries one operation per beat: allocate, free (by byte address) or
// initialise from the memory_kb and reserved_pages registers. rsp_o returns
// exactly one beat per request with status, page address and free count.
// cfg_i writes the two registers and is always ready; write only while idle.
// The bitmap lives in one single-port-read memory of WORDS words; allocate,
// an in-range free and init walk it one word per cycle:
//   allocate : stops at the first word with a free bit
//   free     : steps to the word holding the page
//   init     : rewrites every word
// One operation is in flight at a time. After reset the block writes all
// ones into every bitmap word with req_i not ready. A finished result sits
// in an output register; the next request is taken while it waits, and if
// the receiver still stalls when the next result is ready, that result is
// held until the register drains.

module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGE_COUNT   = MAX_PAGE_COUNT_DEF,
  parameter int unsigned BITMAP_WORD_BITS = BITMAP_WORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpa_cfg_if.sink    cfg_i,
  bpa_req_if.sink    req_i,
  bpa_rsp_if.source  rsp_o
);

  localparam int unsigned WB     = BITMAP_WORD_BITS;
  localparam int unsigned WORDS  = (MAX_PAGE_COUNT + WB - 1) / WB;
  localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BIX_W  = $clog2(WB);
  localparam int unsigned BN_W   = $clog2(WB + 1);
  localparam int unsigned PW     = $clog2(MAX_PAGE_COUNT + 1);
  localparam int unsigned XW     = $clog2(WORDS * WB + 1);
  localparam int unsigned M1     = (XW > PAGE_NUM_W) ? XW : PAGE_NUM_W;
  localparam int unsigned M2     = (M1 > MEM_KB_W) ? M1 : MEM_KB_W;
  localparam int unsigned SW     = M2 + 1;

  // bits below n set
  function automatic logic [WB-1:0] low_mask(input logic [BN_W-1:0] n);
    logic [WB-1:0] m;
    m = '0;
    for (int b = 0; b < WB; b++) begin
      m[b] = (BN_W'(b) < n);
    end
    return m;
  endfunction

  // clamp (bound - base) into 0..WB
  function automatic logic [BN_W-1:0] clamp_off(input logic [SW-1:0] bound,
                                                input logic [SW-1:0] base);
    logic [SW-1:0] diff;
    diff = bound - base;
    if (bound <= base) begin
      return '0;
    end else if (diff >= SW'(WB)) begin
      return BN_W'(WB);
    end else begin
      return BN_W'(diff);
    end
  endfunction

  state_e                state_q, state_d;
  logic [WIDX_W-1:0]     w_q, w_d;
  logic [XW-1:0]         base_q, base_d;
  logic [PAGE_NUM_W-1:0] page_q, page_d;
  logic [PW-1:0]         managed_q, managed_d;
  logic [PW-1:0]         cnt_q, cnt_d;
  logic                  init_pend_q, init_pend_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [ADDR_OUT_W-1:0] res_addr_q, res_addr_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   rsp_status_q, rsp_status_d;
  logic [ADDR_OUT_W-1:0] rsp_addr_q, rsp_addr_d;
  logic [COUNT_W-1:0]    rsp_count_q, rsp_count_d;
  logic [MEM_KB_W-1:0]   memory_kb_q;
  logic [RESERVED_W-1:0] reserved_q;

  logic [WB-1:0]         mem [WORDS];
  logic [WB-1:0]         rdata_q;
  logic                  mem_we;
  logic [WIDX_W-1:0]     mem_waddr;
  logic [WB-1:0]         mem_wdata;
  logic [WIDX_W-1:0]     mem_raddr;

  logic                  zero_found;
  logic [BIX_W-1:0]      zero_pos;
  logic [WB-1:0]         fill_word;
  logic                  seek_hit;
  logic [BIX_W-1:0]      free_bit;
  logic                  last_word;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_kb_q <= '0;
      reserved_q  <= RESERVED_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MEMORY_KB:      memory_kb_q <= MEM_KB_W'(cfg_i.data);
        CFG_RESERVED_PAGES: reserved_q  <= RESERVED_W'(cfg_i.data);
        default:            ;
      endcase
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // lowest free bit of the word just read
  always_comb begin
    zero_found = ~&rdata_q;
    zero_pos   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!rdata_q[b]) begin
        zero_pos = BIX_W'(b);
      end
    end
  end

  // init word: used outside [reserved, managed)
  assign fill_word = ~(low_mask(clamp_off(SW'(managed_q), SW'(base_q))) &
                       ~low_mask(clamp_off(SW'(reserved_q), SW'(base_q))));

  // free path: page lies in the current word
  assign seek_hit  = SW'(page_q) < (SW'(base_q) + SW'(WB));
  assign free_bit  = BIX_W'(SW'(page_q) - SW'(base_q));
  assign last_word = (w_q == WIDX_W'(WORDS - 1));

  // read address: prefetch next word while scanning
  always_comb begin
    case (state_q)
      S_IDLE:  mem_raddr = '0;
      S_ASCAN: mem_raddr = w_q + WIDX_W'(1);
      default: mem_raddr = w_q;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    logic [MEM_KB_W-1:0] pages;
    logic [PW-1:0]       new_man;
    logic [SW-1:0]       pidx;

    state_d      = state_q;
    w_d          = w_q;
    base_d       = base_q;
    page_d       = page_q;
    managed_d    = managed_q;
    cnt_d        = cnt_q;
    init_pend_d  = init_pend_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q & ~rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_addr_d   = rsp_addr_q;
    rsp_count_d  = rsp_count_q;
    mem_we       = 1'b0;
    mem_waddr    = w_q;
    mem_wdata    = fill_word;
    pages        = memory_kb_q >> 2;
    new_man      = (SW'(pages) > SW'(MAX_PAGE_COUNT)) ? PW'(MAX_PAGE_COUNT) : PW'(pages);
    pidx         = SW'(base_q) + SW'(zero_pos);

    case (state_q)
      // write one bitmap word per cycle
      S_FILL: begin
        mem_we = 1'b1;
        w_d    = w_q + WIDX_W'(1);
        base_d = base_q + XW'(WB);
        if (last_word) begin
          w_d          = '0;
          base_d       = '0;
          res_status_d = ST_DONE;
          res_addr_d   = '0;
          state_d      = init_pend_q ? S_DONE : S_IDLE;
          init_pend_d  = 1'b0;
        end
      end

      S_IDLE: begin
        w_d    = '0;
        base_d = '0;
        if (req_i.valid) begin
          res_status_d = ST_DONE;
          res_addr_d   = '0;
          case (req_i.operation)
            OP_ALLOC: state_d = S_ASCAN;
            OP_FREE: begin
              page_d = req_i.free_address[ADDR_IN_W-1:PAGE_SHIFT];
              if (SW'(req_i.free_address[ADDR_IN_W-1:PAGE_SHIFT]) < SW'(managed_q)) begin
                state_d = S_FSEEK;
              end else begin
                res_status_d = ST_IGNORED;
                state_d      = S_DONE;
              end
            end
            OP_INIT: begin
              managed_d   = new_man;
              cnt_d       = (SW'(new_man) > SW'(reserved_q)) ?
                            PW'(SW'(new_man) - SW'(reserved_q)) : '0;
              init_pend_d = 1'b1;
              state_d     = S_FILL;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // first word holding a free bit
      S_ASCAN: begin
        if (zero_found) begin
          mem_we       = 1'b1;
          mem_wdata    = rdata_q | (WB'(1) << zero_pos);
          cnt_d        = (cnt_q != '0) ? cnt_q - PW'(1) : cnt_q;
          res_status_d = ST_DONE;
          res_addr_d   = {(ADDR_OUT_W - PAGE_SHIFT)'(pidx), PAGE_SHIFT'(0)};
          state_d      = S_DONE;
        end else if (last_word) begin
          res_status_d = ST_OOM;
          state_d      = S_DONE;
        end else begin
          w_d    = w_q + WIDX_W'(1);
          base_d = base_q + XW'(WB);
        end
      end

      // step to the word holding the page
      S_FSEEK: begin
        if (seek_hit) begin
          state_d = S_FREAD;
        end else begin
          w_d    = w_q + WIDX_W'(1);
          base_d = base_q + XW'(WB);
        end
      end

      S_FREAD: begin
        if (rdata_q[free_bit]) begin
          mem_we       = 1'b1;
          mem_wdata    = rdata_q & ~(WB'(1) << free_bit);
          cnt_d        = cnt_q + PW'(1);
          res_status_d = ST_DONE;
        end else begin
          res_status_d = ST_IGNORED;
        end
        state_d = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_addr_d   = res_addr_q;
          rsp_count_d  = COUNT_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      w_q         <= '0;
      base_q      <= '0;
      managed_q   <= '0;
      cnt_q       <= '0;
      init_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      base_q      <= base_d;
      managed_q   <= managed_d;
      cnt_q       <= cnt_d;
      init_pend_q <= init_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    rsp_status_q <= rsp_status_d;
    rsp_addr_q   <= rsp_addr_d;
    rsp_count_q  <= rsp_count_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.page_address = rsp_addr_q;
  assign rsp_o.free_count   = rsp_count_q;

endmodule

`default_nettype wire

// ===== sim/bitmap_page_allocator_tb.sv =====
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int unsigned PAGES           = MAX_PAGE_COUNT_DEF;
  localparam int unsigned WORDS           = PAGES / BITMAP_WORD_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS    = 900;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned HOLD_OFF_AFTER  = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES     = WORDS + 16;

  // spare operation code, the block must treat it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ADDR_OUT_W-1:0] page_address;
    logic [COUNT_W-1:0]    free_count;
  } page_rsp_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  code;
    logic [31:0] value;
    logic        known;
    page_rsp_t   want;
  } stim_row_t;

  localparam page_rsp_t NO_RSP = '0;
  localparam int unsigned DIRECTED_COUNT = 33;

  // directed walk: empty block, small pool, page zero, reserved pages, full and capped memory
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_OOM,     24'h0,      13'd0}},
    '{ROW_REQ, OP_FREE,            32'hFFFF_FFFF, 1'b1, '{ST_IGNORED, 24'h0,      13'd0}},
    '{ROW_REQ, OP_FREE,            32'h0000_0000, 1'b1, '{ST_IGNORED, 24'h0,      13'd0}},
    '{ROW_REQ, OP_UNUSED,          32'h5A5A_A5A5, 1'b1, '{ST_DONE,    24'h0,      13'd0}},
    '{ROW_REQ, OP_INIT,            32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd0}},
    '{ROW_CFG, CFG_MEMORY_KB,      32'd64,        1'b0, NO_RSP},
    '{ROW_CFG, CFG_RESERVED_PAGES, 32'd0,         1'b0, NO_RSP},
    '{ROW_REQ, OP_INIT,            32'hFFFF_FFFF, 1'b1, '{ST_DONE,    24'h0,      13'd16}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd15}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_DONE,    24'h1000,   13'd14}},
    '{ROW_REQ, OP_FREE,            32'h0000_0FFF, 1'b1, '{ST_DONE,    24'h0,      13'd15}},
    '{ROW_REQ, OP_FREE,            32'h0000_0ABC, 1'b1, '{ST_IGNORED, 24'h0,      13'd15}},
    '{ROW_REQ, OP_FREE,            32'h0001_0000, 1'b1, '{ST_IGNORED, 24'h0,      13'd15}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd14}},
    '{ROW_CFG, CFG_RESERVED_PAGES, 32'd8,         1'b0, NO_RSP},
    '{ROW_REQ, OP_INIT,            32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd8}},
    '{ROW_REQ, OP_FREE,            32'h0000_7123, 1'b0, NO_RSP},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_CFG, CFG_MEMORY_KB,      32'h007F_FFFF, 1'b0, NO_RSP},
    '{ROW_CFG, CFG_RESERVED_PAGES, 32'd4096,      1'b0, NO_RSP},
    '{ROW_REQ, OP_INIT,            32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd0}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_OOM,     24'h0,      13'd0}},
    '{ROW_CFG, CFG_RESERVED_PAGES, 32'd0,         1'b0, NO_RSP},
    '{ROW_REQ, OP_INIT,            32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd4096}},
    '{ROW_REQ, OP_FREE,            32'hFFFF_F000, 1'b1, '{ST_IGNORED, 24'h0,      13'd4096}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd4095}},
    '{ROW_REQ, OP_FREE,            32'h00FF_F000, 1'b1, '{ST_IGNORED, 24'h0,      13'd4095}},
    '{ROW_CFG, CFG_RESERVED_PAGES, 32'd4095,      1'b0, NO_RSP},
    '{ROW_REQ, OP_INIT,            32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd1}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_DONE,    24'hFFF000, 13'd0}},
    '{ROW_REQ, OP_ALLOC,           32'h0000_0000, 1'b1, '{ST_OOM,     24'h0,      13'd0}},
    '{ROW_CFG, CFG_RESERVED_PAGES, 32'h0000_1FFF, 1'b0, NO_RSP},
    '{ROW_REQ, OP_INIT,            32'h0000_0000, 1'b1, '{ST_DONE,    24'h0,      13'd0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bpa_cfg_if cfg_if ();
  bpa_req_if req_if ();
  bpa_rsp_if rsp_if ();

  bitmap_page_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // own copy of the allocator state and registers
  bit [PAGES-1:0]          used_pages = '1;
  int unsigned             managed_cnt = 0;
  int unsigned             free_cnt = 0;
  logic [MEM_KB_W-1:0]     mem_kb_reg = '0;
  logic [RESERVED_W-1:0]   reserved_reg = RESERVED_RST;

  page_rsp_t   page_results_q [$];
  int unsigned held_pages_q [$];
  int unsigned errors = 0;
  int unsigned rsp_beats = 0;
  bit          req_burst = 1'b0;
  bit          rsp_burst = 1'b0;

  // first-fit allocator behaviour, one operation at a time
  function automatic page_rsp_t apply_page_op(input logic [OP_W-1:0] op,
                                              input logic [ADDR_IN_W-1:0] addr);
    page_rsp_t   r;
    int unsigned pages;
    int unsigned page;
    int unsigned i;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_INIT: begin
        pages = mem_kb_reg / 4;
        if (pages > PAGES) pages = PAGES;
        managed_cnt = pages;
        used_pages = '1;
        free_cnt = 0;
        for (i = reserved_reg; i < managed_cnt; i++) begin
          used_pages[i] = 1'b0;
          free_cnt++;
        end
      end
      OP_ALLOC: begin
        r.status = ST_OOM;
        for (i = 0; i < managed_cnt; i++) begin
          if (!used_pages[i]) begin
            used_pages[i] = 1'b1;
            if (free_cnt > 0) free_cnt--;
            r.page_address = ADDR_OUT_W'(i << PAGE_SHIFT);
            r.status = ST_DONE;
            break;
          end
        end
      end
      OP_FREE: begin
        page = addr >> PAGE_SHIFT;
        if (page < managed_cnt && used_pages[page]) begin
          used_pages[page] = 1'b0;
          free_cnt++;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      default: ;
    endcase
    r.free_count = COUNT_W'(free_cnt);
    return r;
  endfunction

  // mostly short gaps, a few long ones, none in a burst
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // one request beat, then a random gap on the request side
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [ADDR_IN_W-1:0] addr,
                               input bit known, input page_rsp_t want);
    page_rsp_t   got;
    bit          took;
    int unsigned gap;
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.free_address <= addr;
    do begin
      @(negedge clk_i);
      took = req_if.ready;
      @(posedge clk_i);
    end while (!took);
    got = apply_page_op(op, addr);
    page_results_q.push_back(known ? want : got);
    if (op == OP_ALLOC && got.status == ST_DONE) held_pages_q.push_back(got.page_address >> PAGE_SHIFT);
    if (op == OP_INIT) held_pages_q.delete();
    gap = pick_gap(req_burst);
    if (gap > 0) begin
      req_if.valid        <= 1'b0;
      req_if.operation    <= OP_W'($urandom);
      req_if.free_address <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // block idle: nothing in flight and every result back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (page_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    bit took;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do begin
      @(negedge clk_i);
      took = cfg_if.ready;
      @(posedge clk_i);
    end while (!took);
    if (idx == CFG_MEMORY_KB) mem_kb_reg = data[MEM_KB_W-1:0];
    else if (idx == CFG_RESERVED_PAGES) reserved_reg = data[RESERVED_W-1:0];
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stimulus: reset, directed table, then random phases
  initial begin
    int unsigned           n;
    int unsigned           rand_items;
    int unsigned           phase_len;
    int unsigned           r;
    int unsigned           pages;
    int unsigned           page;
    int unsigned           idx;
    logic [CFG_DATA_W-1:0] mem_val;
    logic [CFG_DATA_W-1:0] resv_val;
    logic [OP_W-1:0]       op;
    logic [ADDR_IN_W-1:0]  addr;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_ALLOC;
    req_if.free_address <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_MEMORY_KB;
    cfg_if.data         <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DIRECTED_COUNT; n++) begin
      if (DIRECTED_ROWS[n].kind == ROW_CFG) begin
        drain_results();
        write_register(DIRECTED_ROWS[n].code, DIRECTED_ROWS[n].value[CFG_DATA_W-1:0]);
      end else begin
        issue_request(DIRECTED_ROWS[n].code, DIRECTED_ROWS[n].value,
                      DIRECTED_ROWS[n].known, DIRECTED_ROWS[n].want);
      end
    end

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      drain_results();
      // memory size: mostly small pools that run dry, sometimes extremes
      case ($urandom_range(0, 11))
        0:       mem_val = '0;
        1:       mem_val = CFG_DATA_W'(4194304);
        2:       mem_val = CFG_DATA_W'(23'h7FFFFF);
        3:       mem_val = CFG_DATA_W'($urandom);
        4:       mem_val = CFG_DATA_W'($urandom_range(16384, 16387));
        default: mem_val = CFG_DATA_W'($urandom_range(0, 1200));
      endcase
      pages = mem_val / 4;
      if (pages > PAGES) pages = PAGES;
      case ($urandom_range(0, 9))
        0:       resv_val = '0;
        1:       resv_val = CFG_DATA_W'(13'h1FFF);
        2:       resv_val = CFG_DATA_W'($urandom_range(0, 8191));
        3:       resv_val = CFG_DATA_W'(pages);
        default: resv_val = CFG_DATA_W'($urandom_range(0, pages > 64 ? 64 : pages));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_register(CFG_MEMORY_KB, mem_val);
        write_register(CFG_RESERVED_PAGES, resv_val);
      end else begin
        write_register(CFG_RESERVED_PAGES, resv_val);
        write_register(CFG_MEMORY_KB, mem_val);
      end
      req_burst = ($urandom_range(0, 4) == 0);
      issue_request(OP_INIT, $urandom, 1'b0, NO_RSP);
      rand_items++;

      // allocate/free traffic on held pages, with some noise
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        op = OP_ALLOC;
        addr = $urandom;
        if (r >= 50 && r < 82 && held_pages_q.size() != 0) begin
          idx = $urandom_range(0, held_pages_q.size() - 1);
          page = held_pages_q[idx];
          held_pages_q.delete(idx);
          op = OP_FREE;
          addr = (page << PAGE_SHIFT) | ($urandom & 32'hFFF);
        end else if (r >= 82 && r < 88) begin
          op = OP_FREE;
        end else if (r >= 88 && r < 92) begin
          page = (managed_cnt > 0) ? $urandom_range(0, managed_cnt - 1) : $urandom_range(0, PAGES - 1);
          op = OP_FREE;
          addr = (page << PAGE_SHIFT) | ($urandom & 32'hFFF);
        end else if (r >= 92 && r < 96) begin
          op = OP_UNUSED;
        end else if (r >= 96) begin
          op = OP_INIT;
        end
        issue_request(op, addr, 1'b0, NO_RSP);
        rand_items++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("bitmap_page_allocator_tb passed");
    end else begin
      $display("bitmap_page_allocator_tb failed");
    end
    $finish;
  end

  // response side: random stalls, one long hold-off, field checks
  initial begin
    int unsigned stall_left;
    bit          held_off;
    page_rsp_t   want;
    stall_left = 0;
    held_off = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
      @(negedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (page_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d address 0x%0h count %0d",
                   $time, rsp_if.status, rsp_if.page_address, rsp_if.free_count);
          errors++;
        end else begin
          want = page_results_q.pop_front();
          compare_field("status", want.status, rsp_if.status);
          compare_field("page_address", want.page_address, rsp_if.page_address);
          compare_field("free_count", want.free_count, rsp_if.free_count);
        end
        rsp_beats++;
        if (rsp_beats % 64 == 0) rsp_burst = ($urandom_range(0, 2) == 0);
        stall_left = pick_gap(rsp_burst);
      end
      // long hold-off while requests keep coming, so the block backs up
      if (!held_off && rsp_beats >= HOLD_OFF_AFTER && req_if.valid === 1'b1) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
    end
  end

  // watchdog: too long without any beat on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("bitmap_page_allocator_tb failed");
        $finish;
      end
    end
  end

endmodule
